@@ rtl/core/mwrm_pkg.sv @@
// Shared types and constants for the Microwire read master.
`default_nettype none
package mwrm_pkg;

    localparam int WORD_BITS_DEF = 16;
    localparam int ADDR_BITS_MAX = 8;
    localparam int SHIFT_W       = 3 + ADDR_BITS_MAX;

    localparam logic [7:0] PIN_CS = 8'h02;
    localparam logic [7:0] PIN_SK = 8'h20;
    localparam logic [7:0] PIN_DI = 8'h40;

    // Start bit followed by the READ opcode 1,0.
    localparam logic [2:0] READ_CMD = 3'b110;

    localparam int DO_BIT = 5;

    localparam int APB_ADDR_W = 4;

    typedef enum logic [1:0] {
        REG_IDLE_MASK   = 2'd0,
        REG_ADDR_BITS   = 2'd1,
        REG_IDLE_STATUS = 2'd2,
        REG_NONE        = 2'd3
    } reg_idx_t;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_CS_UP    = 4'd1,
        PH_SEND_DI  = 4'd2,
        PH_SEND_SKH = 4'd3,
        PH_SEND_SKL = 4'd4,
        PH_RECV_SKH = 4'd5,
        PH_RECV_SKL = 4'd6,
        PH_CS_DOWN  = 4'd7,
        PH_FINISH   = 4'd8
    } phase_t;

    typedef struct packed {
        logic [7:0] idle_mask;
        logic [3:0] addr_bits;
        logic [7:0] idle_status;
    } cfg_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  address;
        logic [7:0]  status_in;
    } item_t;

    typedef struct packed {
        logic        do_moved;
        logic [15:0] word_out;
        logic        read_done;
        logic        busy_res;
        logic [7:0]  port_byte;
    } res_t;

endpackage
`default_nettype wire

@@ rtl/core/mwrm_cfg_regs.sv @@
// APB configuration registers of the Microwire read master.
`default_nettype none
module mwrm_cfg_regs
(
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire  [mwrm_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire  [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output mwrm_pkg::cfg_t                    cfg
);
    import mwrm_pkg::*;

    logic [7:0] idle_mask_reg;
    logic [3:0] addr_bits_reg;
    logic [7:0] idle_status_reg;
    reg_idx_t   idx;
    logic       wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_mask_reg   <= 8'h00;
            addr_bits_reg   <= 4'd6;
            idle_status_reg <= 8'h00;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_IDLE_MASK:   idle_mask_reg   <= pwdata[7:0];
                REG_ADDR_BITS:   addr_bits_reg   <= pwdata[3:0];
                REG_IDLE_STATUS: idle_status_reg <= pwdata[7:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_IDLE_MASK:   prdata = {24'h0, idle_mask_reg};
            REG_ADDR_BITS:   prdata = {28'h0, addr_bits_reg};
            REG_IDLE_STATUS: prdata = {24'h0, idle_status_reg};
            default:         prdata = 32'h0;
        endcase
    end

    assign cfg.idle_mask   = idle_mask_reg;
    assign cfg.addr_bits   = addr_bits_reg;
    assign cfg.idle_status = idle_status_reg;
endmodule
`default_nettype wire

@@ rtl/core/mwrm_seq.sv @@
// Pin sequencer: transaction state and the result of each accepted beat.
`default_nettype none
module mwrm_seq
#(
    parameter int WORD_BITS = mwrm_pkg::WORD_BITS_DEF
)
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                step,
    input  mwrm_pkg::item_t    item,
    input  mwrm_pkg::cfg_t     cfg,
    output mwrm_pkg::res_t     res
);
    import mwrm_pkg::*;

    localparam int CNT_MAX = (WORD_BITS > SHIFT_W) ? WORD_BITS : SHIFT_W;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);

    phase_t               phase_reg,  phase_next;
    logic [CNT_W-1:0]     count_reg,  count_next;
    logic [WORD_BITS-1:0] rx_reg,     rx_next;
    logic [SHIFT_W-1:0]   ashift_reg, ashift_next;
    logic [7:0]           pin_reg,    pin_next;
    logic                 moved_reg,  moved_next;

    logic                 start;
    logic                 done;
    logic [3:0]           nbits;
    logic [7:0]           amask;
    logic [SHIFT_W-1:0]   ashift_load;
    logic [CNT_W-1:0]     count_dec;
    logic [3:0]           di_idx;
    logic                 di_bit;

    assign start = item.kind && (phase_reg == PH_IDLE);

    // Address widths above eight are clamped to eight.
    assign nbits       = (cfg.addr_bits > 4'(ADDR_BITS_MAX)) ? 4'(ADDR_BITS_MAX)
                                                             : cfg.addr_bits;
    assign amask       = 8'((9'd1 << nbits) - 9'd1);
    assign ashift_load = (SHIFT_W'(READ_CMD) << nbits) | SHIFT_W'(item.address & amask);
    assign count_dec   = (count_reg != '0) ? count_reg - CNT_W'(1) : count_reg;
    assign di_idx      = 4'(count_reg - CNT_W'(1));
    assign di_bit      = ashift_reg[di_idx];

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (item.kind)
        begin
            if (start)
                phase_next = PH_CS_UP;
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:     phase_next = PH_IDLE;
                PH_CS_UP:    phase_next = PH_SEND_DI;
                PH_SEND_DI:  phase_next = PH_SEND_SKH;
                PH_SEND_SKH: phase_next = PH_SEND_SKL;
                PH_SEND_SKL: phase_next = (count_dec == '0) ? PH_RECV_SKH : PH_SEND_DI;
                PH_RECV_SKH: phase_next = PH_RECV_SKL;
                PH_RECV_SKL: phase_next = (count_dec == '0) ? PH_CS_DOWN : PH_RECV_SKH;
                PH_CS_DOWN:  phase_next = PH_FINISH;
                PH_FINISH:   phase_next = PH_IDLE;
                default:     phase_next = PH_IDLE;
            endcase
        end
    end

    // Datapath and pin updates
    always_comb
    begin
        count_next  = count_reg;
        rx_next     = rx_reg;
        ashift_next = ashift_reg;
        pin_next    = pin_reg;
        moved_next  = moved_reg;
        done        = 1'b0;
        if (item.kind)
        begin
            if (start)
            begin
                ashift_next = ashift_load;
                count_next  = CNT_W'(nbits) + CNT_W'(3);
                rx_next     = '0;
                moved_next  = 1'b0;
                pin_next    = cfg.idle_mask;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_CS_UP:
                    pin_next = pin_reg | PIN_CS | cfg.idle_mask;
                PH_SEND_DI:
                    pin_next = (di_bit ? (pin_reg | PIN_DI) : (pin_reg & ~PIN_DI))
                               | cfg.idle_mask;
                PH_SEND_SKH, PH_RECV_SKH:
                    pin_next = pin_reg | PIN_SK | cfg.idle_mask;
                PH_SEND_SKL:
                begin
                    pin_next   = (pin_reg & ~PIN_SK) | cfg.idle_mask;
                    count_next = (count_dec == '0) ? CNT_W'(WORD_BITS) : count_dec;
                end
                PH_RECV_SKL:
                begin
                    pin_next   = (pin_reg & ~PIN_SK) | cfg.idle_mask;
                    count_next = count_dec;
                    rx_next    = {rx_reg[WORD_BITS-2:0], item.status_in[DO_BIT]};
                    if (item.status_in != cfg.idle_status)
                        moved_next = 1'b1;
                end
                PH_CS_DOWN:
                    pin_next = (pin_reg & ~PIN_CS) | cfg.idle_mask;
                PH_FINISH:
                begin
                    pin_next = cfg.idle_mask;
                    done     = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            count_reg  <= '0;
            rx_reg     <= '0;
            ashift_reg <= '0;
            pin_reg    <= '0;
            moved_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            rx_reg     <= rx_next;
            ashift_reg <= ashift_next;
            pin_reg    <= pin_next;
            moved_reg  <= moved_next;
        end
    end

    assign res.port_byte = pin_next;
    assign res.busy_res  = (phase_next != PH_IDLE);
    assign res.read_done = done;
    assign res.word_out  = done ? 16'(rx_reg) : 16'h0;
    assign res.do_moved  = moved_next;
endmodule
`default_nettype wire

@@ rtl/core/microwire_read_master_unit.sv @@
// Microwire READ master: one pin update of the serial EEPROM bus per input beat.
//
// Input stream: tuser = kind (1 starts a read, 0 is a tick that makes one pin
// update); tdata carries the word address and the sampled status port byte.
// Every input beat produces exactly one output beat holding the data port byte
// to write (CS bit 1, SK bit 5, DI bit 6, idle mask ORed in), the busy flag,
// the done flag with the 16-bit received word, and the status-moved flag.
// A start while a read is in progress changes nothing; a tick while idle
// repeats the held port byte.
// The result of a beat accepted at one edge is shown from that edge on in the
// output register. One beat per cycle is sustained; the state update and the
// result are one pass of logic behind the output register, so the input is
// taken whenever that register is empty or is being emptied in the same cycle.
// When the receiver stalls, the result holds and s_axis_tready falls until it
// is taken. Reset clears the transaction state, the output register and the
// configuration (idle mask 0, six address bits, idle status 0). Registers are
// written over APB at 0x0, 0x4 and 0x8; the user must write them only while
// the block is idle, which the block itself does not enforce.
`default_nettype none
module microwire_read_master_unit
#(
    parameter int WORD_BITS = mwrm_pkg::WORD_BITS_DEF
)
(
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire  [15:0]                      s_axis_tdata,  // address[7:0], status_in[15:8]
    input  wire  [0:0]                       s_axis_tuser,  // kind
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    // port_byte[7:0], busy_res[8], read_done[9], word_out[25:10], do_moved[26], zero pad
    output logic [31:0]                      m_axis_tdata,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [mwrm_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire  [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import mwrm_pkg::*;

    cfg_t  cfg;
    item_t item;
    res_t  res;
    res_t  out_reg;
    logic  valid_reg;
    logic  step;

    assign s_axis_tready = !valid_reg || m_axis_tready;
    assign step          = s_axis_tvalid && s_axis_tready;

    assign item.kind      = s_axis_tuser[0];
    assign item.address   = s_axis_tdata[7:0];
    assign item.status_in = s_axis_tdata[15:8];

    mwrm_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mwrm_seq #(.WORD_BITS(WORD_BITS)) u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (item),
        .cfg   (cfg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (step)
            valid_reg <= 1'b1;
        else if (m_axis_tready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_reg <= '0;
        else if (step)
            out_reg <= res;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {5'h0, out_reg};
endmodule
`default_nettype wire

@@ rtl/core/mwrm_checker.sv @@
// Port-level checks for the Microwire read master, bound to the top level.
`default_nettype none
module mwrm_checker
(
    input wire        clk,
    input wire        rst_n,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [31:0] m_axis_tdata
);
    // The finishing beat always leaves the block idle.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[9] |-> !m_axis_tdata[8])
        else $error("read_done shown while busy_res is set");

    // The received word is only reported with the done flag.
    a_word_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[9] |-> (m_axis_tdata[25:10] == 16'h0))
        else $error("word_out non-zero without read_done");

    // The input side only stalls while a result waits on a stalled receiver.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without a pending output beat");

    // A stalled output beat holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");
endmodule

bind microwire_read_master_unit mwrm_checker u_mwrm_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
